// File: rtl/pflm_pkg.sv
// ----------------------------------------------------------------------------
// pflm_pkg
// shared widths, command and status codes, and controller/datapath bundles
// for the page frame list manager
// ----------------------------------------------------------------------------
package pflm_pkg;

    localparam int CMD_W    = 2;
    localparam int LIST_W   = 2;
    localparam int FRAME_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // commands
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNLINK   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNLINKED = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clear;     // write one "not linked" entry of the clearing pass
        logic capture;   // take the input item
        logic step1;     // decide, write own links, update sentinels and count
        logic step2;     // write the neighbor links
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last entry
    } t_dp_stat;

endpackage

// File: rtl/pflm_ram.sv
// ----------------------------------------------------------------------------
// pflm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pflm_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]       i_wr_addr,
    input  logic [WIDTH-1:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]       i_rd_addr,
    output logic [WIDTH-1:0]               o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: rtl/pflm_ctrl.sv
// ----------------------------------------------------------------------------
// pflm_ctrl
// sequencer: clearing pass, item capture, two work steps, result hand-off
// ----------------------------------------------------------------------------
module pflm_ctrl import pflm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_STEP1 = 3'd2;
    localparam logic [2:0] S_STEP2 = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step1    = (r_state == S_STEP1);
        o_cmd.step2    = (r_state == S_STEP2);
        o_cmd.load_out = ((r_state == S_STEP2) || (r_state == S_HOLD)) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_STEP1;
                end
            end
            S_STEP1: begin
                n_state = S_STEP2;
            end
            S_STEP2, S_HOLD: begin
                n_state = out_free ? S_IDLE : S_HOLD;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/pflm_dp.sv
// ----------------------------------------------------------------------------
// pflm_dp
// link memories, list sentinels and counts, link update logic, result register
// ----------------------------------------------------------------------------
module pflm_dp import pflm_pkg::*; #(
    parameter int NUM_FRAMES = 1024,
    parameter int NUM_LISTS  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [LIST_W-1:0]   i_list_id,
    input  logic [FRAME_W-1:0]  i_frame_number,
    input  logic                i_frame_busy,
    output logic [STATUS_W-1:0] o_status,
    output logic [FRAME_W-1:0]  o_popped_frame,
    output logic [COUNT_W-1:0]  o_list_count
);

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int LW  = $clog2(NUM_FRAMES + NUM_LISTS + 1);
    localparam int LIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    localparam logic [LW-1:0] FIRST_SENT = LW'(NUM_FRAMES);
    localparam logic [LW-1:0] NL_CODE    = LW'(NUM_FRAMES + NUM_LISTS);
    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

    function automatic logic is_frame(input logic [LW-1:0] code);
        return code < FIRST_SENT;
    endfunction

    function automatic logic is_sent(input logic [LW-1:0] code);
        return (code >= FIRST_SENT) && (code < NL_CODE);
    endfunction

    function automatic logic [LIW-1:0] sent_idx(input logic [LW-1:0] code);
        logic [LW-1:0] diff;
        diff = code - FIRST_SENT;
        return LIW'(diff);
    endfunction

    // sentinels and counts
    logic [LW-1:0]      r_head_next [NUM_LISTS];
    logic [LW-1:0]      r_head_prev [NUM_LISTS];
    logic [COUNT_W-1:0] r_count     [NUM_LISTS];

    // clearing pass
    logic [FW-1:0] r_clr_addr;

    // captured item
    logic [CMD_W-1:0]   r_cmd;
    logic [LIST_W-1:0]  r_list;
    logic [FRAME_W-1:0] r_frame;
    logic               r_busy;
    logic [LW-1:0]      r_hn;
    logic [LW-1:0]      r_hp;
    logic [COUNT_W-1:0] r_cnt;

    // neighbor writes for step 2
    logic          r_nbn_en, r_nbp_en;
    logic [FW-1:0] r_nbn_addr, r_nbp_addr;
    logic [LW-1:0] r_nbn_data, r_nbp_data;

    // result held until the output register frees
    logic [STATUS_W-1:0] r_res_status;
    logic [FRAME_W-1:0]  r_res_popped;
    logic [COUNT_W-1:0]  r_res_count;

    // input side lookup
    logic               in_list_ok;
    logic [LIW-1:0]     in_idx;
    logic [LW-1:0]      in_hn;
    logic [LW-1:0]      in_hp;
    logic [COUNT_W-1:0] in_cnt;
    logic [FW-1:0]      rd_addr;

    // ram ports
    logic          next_we, prev_we;
    logic [FW-1:0] next_waddr, prev_waddr;
    logic [LW-1:0] next_wdata, prev_wdata;
    logic [LW-1:0] rd_next, rd_prev;

    // step 1 decisions
    logic                l_ok;
    logic [LIW-1:0]      lidx;
    logic [LW-1:0]       sent;
    logic                f_ok;
    logic [LW-1:0]       fcode;
    logic [STATUS_W-1:0] st;
    logic [FRAME_W-1:0]  popped;
    logic [COUNT_W-1:0]  cnt_up, cnt_dn, cnt_new;
    logic                self_we;
    logic [FW-1:0]       self_addr;
    logic [LW-1:0]       self_next, self_prev;
    logic                nbn_en, nbp_en;
    logic [FW-1:0]       nbn_addr, nbp_addr;
    logic [LW-1:0]       nbn_data, nbp_data;
    logic                hn_we, hp_we;
    logic [LIW-1:0]      hn_idx, hp_idx;
    logic [LW-1:0]       hn_val, hp_val;

    assign in_list_ok = int'(i_list_id) < NUM_LISTS;
    assign in_idx     = LIW'(i_list_id);
    assign in_hn      = in_list_ok ? r_head_next[in_idx] : NL_CODE;
    assign in_hp      = in_list_ok ? r_head_prev[in_idx] : NL_CODE;
    assign in_cnt     = in_list_ok ? r_count[in_idx] : '0;
    // pop reads the head's forward link, the others read the named frame
    assign rd_addr    = (i_command == CMD_POP_HEAD) ? FW'(in_hn) : FW'(i_frame_number);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_list  <= i_list_id;
            r_frame <= i_frame_number;
            r_busy  <= i_frame_busy;
            r_hn    <= in_hn;
            r_hp    <= in_hp;
            r_cnt   <= in_cnt;
        end
    end

    always_comb begin
        l_ok      = int'(r_list) < NUM_LISTS;
        lidx      = LIW'(r_list);
        sent      = FIRST_SENT + LW'(lidx);
        f_ok      = int'(r_frame) < NUM_FRAMES;
        fcode     = LW'(r_frame);
        cnt_up    = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + COUNT_W'(1);
        cnt_dn    = (r_cnt == '0) ? r_cnt : r_cnt - COUNT_W'(1);
        st        = ST_OK;
        popped    = '0;
        cnt_new   = r_cnt;
        self_we   = 1'b0;
        self_addr = FW'(r_frame);
        self_next = NL_CODE;
        self_prev = NL_CODE;
        nbn_en    = 1'b0;
        nbn_addr  = '0;
        nbn_data  = NL_CODE;
        nbp_en    = 1'b0;
        nbp_addr  = '0;
        nbp_data  = NL_CODE;
        hn_we     = 1'b0;
        hn_idx    = lidx;
        hn_val    = NL_CODE;
        hp_we     = 1'b0;
        hp_idx    = lidx;
        hp_val    = NL_CODE;
        if (!l_ok) begin
            st = ST_EMPTY;
        end else if ((r_cmd != CMD_POP_HEAD) && !f_ok) begin
            st = ST_UNLINKED;
        end else begin
            case (r_cmd)
                CMD_INS_HEAD: begin
                    if (r_busy) begin
                        st = ST_BUSY;
                    end else begin
                        self_we   = 1'b1;
                        self_next = r_hn;
                        self_prev = sent;
                        hn_we     = 1'b1;
                        hn_val    = fcode;
                        if (is_sent(r_hn)) begin
                            hp_we  = 1'b1;
                            hp_idx = sent_idx(r_hn);
                            hp_val = fcode;
                        end
                        // old head pointing at itself: own back link wins
                        if (is_frame(r_hn) && (r_hn != fcode)) begin
                            nbp_en   = 1'b1;
                            nbp_addr = FW'(r_hn);
                            nbp_data = fcode;
                        end
                        cnt_new = cnt_up;
                    end
                end
                CMD_INS_TAIL: begin
                    self_we   = 1'b1;
                    self_next = sent;
                    self_prev = r_hp;
                    hp_we     = 1'b1;
                    hp_val    = fcode;
                    if (is_sent(r_hp)) begin
                        hn_we  = 1'b1;
                        hn_idx = sent_idx(r_hp);
                        hn_val = fcode;
                    end
                    // the tail's forward link is written last, even onto itself
                    if (is_frame(r_hp)) begin
                        nbn_en   = 1'b1;
                        nbn_addr = FW'(r_hp);
                        nbn_data = fcode;
                    end
                    cnt_new = cnt_up;
                end
                CMD_POP_HEAD: begin
                    if (!is_frame(r_hn)) begin
                        st = ST_EMPTY;
                    end else begin
                        hn_we  = 1'b1;
                        hn_val = rd_next;
                        if (is_sent(rd_next)) begin
                            hp_we  = 1'b1;
                            hp_idx = sent_idx(rd_next);
                            hp_val = sent;
                        end
                        if (is_frame(rd_next) && (rd_next != r_hn)) begin
                            nbp_en   = 1'b1;
                            nbp_addr = FW'(rd_next);
                            nbp_data = sent;
                        end
                        self_we   = 1'b1;
                        self_addr = FW'(r_hn);
                        popped    = FRAME_W'(r_hn);
                        cnt_new   = cnt_dn;
                    end
                end
                CMD_UNLINK: begin
                    if (r_hn == sent) begin
                        st = ST_EMPTY;
                    end else if ((rd_next == NL_CODE) && (rd_prev == NL_CODE)) begin
                        st = ST_UNLINKED;
                    end else begin
                        if (is_sent(rd_next)) begin
                            hp_we  = 1'b1;
                            hp_idx = sent_idx(rd_next);
                            hp_val = rd_prev;
                        end
                        if (is_frame(rd_next) && (rd_next != fcode)) begin
                            nbp_en   = 1'b1;
                            nbp_addr = FW'(rd_next);
                            nbp_data = rd_prev;
                        end
                        if (is_sent(rd_prev)) begin
                            hn_we  = 1'b1;
                            hn_idx = sent_idx(rd_prev);
                            hn_val = rd_next;
                        end
                        if (is_frame(rd_prev) && (rd_prev != fcode)) begin
                            nbn_en   = 1'b1;
                            nbn_addr = FW'(rd_prev);
                            nbn_data = rd_next;
                        end
                        self_we = 1'b1;
                        cnt_new = cnt_dn;
                    end
                end
                default: begin
                    st = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head_next[i] <= FIRST_SENT + LW'(i);
                r_head_prev[i] <= FIRST_SENT + LW'(i);
                r_count[i]     <= '0;
            end
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + FW'(1);
            end
            if (i_cmd.step1) begin
                if (hn_we) begin
                    r_head_next[hn_idx] <= hn_val;
                end
                if (hp_we) begin
                    r_head_prev[hp_idx] <= hp_val;
                end
                if (l_ok) begin
                    r_count[lidx] <= cnt_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step1) begin
            r_nbn_en     <= nbn_en;
            r_nbn_addr   <= nbn_addr;
            r_nbn_data   <= nbn_data;
            r_nbp_en     <= nbp_en;
            r_nbp_addr   <= nbp_addr;
            r_nbp_data   <= nbp_data;
            r_res_status <= st;
            r_res_popped <= popped;
            r_res_count  <= l_ok ? cnt_new : '0;
        end
        if (i_cmd.load_out) begin
            o_status       <= r_res_status;
            o_popped_frame <= r_res_popped;
            o_list_count   <= r_res_count;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == LAST_FRAME);

    always_comb begin
        next_we    = 1'b0;
        next_waddr = self_addr;
        next_wdata = self_next;
        prev_we    = 1'b0;
        prev_waddr = self_addr;
        prev_wdata = self_prev;
        if (i_cmd.clear) begin
            next_we    = 1'b1;
            next_waddr = r_clr_addr;
            next_wdata = NL_CODE;
            prev_we    = 1'b1;
            prev_waddr = r_clr_addr;
            prev_wdata = NL_CODE;
        end else if (i_cmd.step1) begin
            next_we = self_we;
            prev_we = self_we;
        end else if (i_cmd.step2) begin
            next_we    = r_nbn_en;
            next_waddr = r_nbn_addr;
            next_wdata = r_nbn_data;
            prev_we    = r_nbp_en;
            prev_waddr = r_nbp_addr;
            prev_wdata = r_nbp_data;
        end
    end

    pflm_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_FRAMES)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_waddr),
        .i_wr_data (next_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_next)
    );

    pflm_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_FRAMES)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_waddr),
        .i_wr_data (prev_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_prev)
    );

endmodule

// File: rtl/page_frame_list_manager_top.sv
// ----------------------------------------------------------------------------
// page_frame_list_manager_top
// circular doubly linked lists of page frames with per-list head, tail, count
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall, item = command, list id, frame
//   number and busy flag; taken at a clock edge with valid high, stall low
//   output channel: o_out_valid / i_out_stall, one result item per input item
//   (status, popped frame, list count after the command), in input order
//   steps: an item is taken, then two work steps run (decide and write the
//   frame's own links, then write the neighbor links); the result is then
//   loaded into the output register, and only after that hand-off can the
//   next item be taken: the accepting cycle starts the registered link read,
//   then the single write port of each link memory takes the two writes of
//   a relink, one in each work step
//   receiver stall: the result waits in the output register; a new item is
//   still taken, and its result waits in the datapath until the output frees
//   reset: i_rst_n low, synchronous; afterwards a clearing pass marks every
//   frame not linked, one entry a cycle, with o_in_stall held high
// ----------------------------------------------------------------------------
module page_frame_list_manager_top import pflm_pkg::*; #(
    parameter int NUM_FRAMES = 1024,
    parameter int NUM_LISTS  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [LIST_W-1:0]   i_list_id,
    input  logic [FRAME_W-1:0]  i_frame_number,
    input  logic                i_frame_busy,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [FRAME_W-1:0]  o_popped_frame,
    output logic [COUNT_W-1:0]  o_list_count
);

    // command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: clearing pass, capture, two steps, output hand-off
    pflm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // link memories, sentinels, counts and the result register
    pflm_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_LISTS  (NUM_LISTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_command),
        .i_list_id      (i_list_id),
        .i_frame_number (i_frame_number),
        .i_frame_busy   (i_frame_busy),
        .o_status       (o_status),
        .o_popped_frame (o_popped_frame),
        .o_list_count   (o_list_count)
    );

endmodule

// File: rtl/pflm_checker.sv
// ----------------------------------------------------------------------------
// pflm_checker
// port level checks of the page frame list manager, bound to the top level
// ----------------------------------------------------------------------------
module pflm_checker import pflm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [FRAME_W-1:0]  o_popped_frame,
    input logic [COUNT_W-1:0]  o_list_count
);

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // one item at a time: the input closes after a take
    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    // a fresh result must follow a taken item
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_take, 3))
        else $error("result appeared without an item three cycles before");

    // only a good pop returns a frame
    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_popped_frame == '0))
        else $error("frame returned on a refused command");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_popped_frame)
             && $stable(o_list_count)))
        else $error("stalled result changed");

endmodule

bind page_frame_list_manager_top pflm_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_popped_frame (o_popped_frame),
    .o_list_count   (o_list_count)
);

// File: dv/page_frame_list_manager_top_tb.sv
// ----------------------------------------------------------------------------
// page_frame_list_manager_top_tb
// self-checking bench for the page frame list manager: a short table of
// directed items, then random insert / pop / unlink traffic; every result
// item is compared with a typed row's written want, else with a behavioral list model kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module page_frame_list_manager_top_tb import pflm_pkg::*; ();

    localparam int NUM_FRAMES   = 1024;
    localparam int NUM_LISTS    = 4;
    localparam int RANDOM_ITEMS = 1750;
    localparam int ROW_COUNT    = 25;
    localparam int MAX_SHOWN    = 10;

    // link codes: frames are 0..NUM_FRAMES-1, list l's sentinel is NUM_FRAMES+l
    localparam logic [COUNT_W-1:0] NO_LINK = COUNT_W'(NUM_FRAMES + NUM_LISTS);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  popped;
        logic [COUNT_W-1:0]  count;
    } t_frame_result;

    // one row of the directed table; typed == 1 means want is checked as written
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [LIST_W-1:0]  lst;
        logic [FRAME_W-1:0] frm;
        logic               busy;
        logic               typed;
        t_frame_result      want;
    } t_directed_row;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command      = CMD_INS_HEAD;
    logic [LIST_W-1:0]   i_list_id      = '0;
    logic [FRAME_W-1:0]  i_frame_number = '0;
    logic                i_frame_busy   = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [FRAME_W-1:0]  o_popped_frame;
    logic [COUNT_W-1:0]  o_list_count;

    page_frame_list_manager_top #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_LISTS  (NUM_LISTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_list_id      (i_list_id),
        .i_frame_number (i_frame_number),
        .i_frame_busy   (i_frame_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_frame (o_popped_frame),
        .o_list_count   (o_list_count)
    );

    always #5 i_clk = ~i_clk;

    // list model: forward / back links per frame, head / tail / length per list
    logic [COUNT_W-1:0] fwd_link  [NUM_FRAMES];
    logic [COUNT_W-1:0] back_link [NUM_FRAMES];
    logic [COUNT_W-1:0] list_head [NUM_LISTS];
    logic [COUNT_W-1:0] list_tail [NUM_LISTS];
    logic [COUNT_W-1:0] list_len  [NUM_LISTS];

    // bench bookkeeping of which frames really sit on a list, and which one
    logic               on_list    [NUM_FRAMES];
    logic [LIST_W-1:0]  owner_list [NUM_FRAMES];
    int                 linked_pool[$];

    t_frame_result      expected_results[$];
    int                 err_count   = 0;
    int                 result_seen = 0;
    int                 cmd_seen    [4] = '{0, 0, 0, 0};
    int                 status_seen [4] = '{0, 0, 0, 0};
    logic               no_idle     = 1'b0;

    // directed items: empty list, busy refusal, extremes of the frame range,
    // unlink of a frame that is not linked, head / middle / tail / sole unlink,
    // unlink naming the wrong list (count drifts), pop after that drift
    t_directed_row directed_rows [ROW_COUNT] = '{
        '{CMD_POP_HEAD, 2'd0, 10'd0,    1'b0, 1'b1, '{ST_EMPTY,    10'd0,    11'd0}},
        '{CMD_UNLINK,   2'd3, 10'd5,    1'b0, 1'b1, '{ST_EMPTY,    10'd0,    11'd0}},
        '{CMD_INS_HEAD, 2'd0, 10'd0,    1'b1, 1'b1, '{ST_BUSY,     10'd0,    11'd0}},
        '{CMD_INS_HEAD, 2'd0, 10'd0,    1'b0, 1'b1, '{ST_OK,       10'd0,    11'd1}},
        '{CMD_INS_TAIL, 2'd0, 10'd1023, 1'b1, 1'b1, '{ST_OK,       10'd0,    11'd2}},
        '{CMD_INS_HEAD, 2'd3, 10'd512,  1'b0, 1'b1, '{ST_OK,       10'd0,    11'd1}},
        '{CMD_UNLINK,   2'd0, 10'd700,  1'b0, 1'b1, '{ST_UNLINKED, 10'd0,    11'd2}},
        '{CMD_POP_HEAD, 2'd0, 10'd1023, 1'b1, 1'b1, '{ST_OK,       10'd0,    11'd1}},
        '{CMD_POP_HEAD, 2'd0, 10'd0,    1'b0, 1'b1, '{ST_OK,       10'd1023, 11'd0}},
        '{CMD_POP_HEAD, 2'd0, 10'd0,    1'b0, 1'b1, '{ST_EMPTY,    10'd0,    11'd0}},
        '{CMD_INS_TAIL, 2'd2, 10'd10,   1'b0, 1'b0, '0},
        '{CMD_INS_TAIL, 2'd2, 10'd11,   1'b0, 1'b0, '0},
        '{CMD_INS_HEAD, 2'd2, 10'd12,   1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd2, 10'd11,   1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd2, 10'd12,   1'b0, 1'b0, '0},
        '{CMD_INS_TAIL, 2'd2, 10'd13,   1'b0, 1'b0, '0},
        '{CMD_INS_TAIL, 2'd2, 10'd14,   1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd2, 10'd13,   1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd2, 10'd10,   1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd2, 10'd14,   1'b0, 1'b0, '0},
        '{CMD_INS_HEAD, 2'd1, 10'd700,  1'b0, 1'b0, '0},
        '{CMD_UNLINK,   2'd1, 10'd512,  1'b0, 1'b0, '0},
        '{CMD_POP_HEAD, 2'd3, 10'd0,    1'b0, 1'b0, '0},
        '{CMD_POP_HEAD, 2'd1, 10'd341,  1'b0, 1'b0, '0},
        '{CMD_INS_TAIL, 2'd1, 10'd682,  1'b1, 1'b0, '0}
    };

    // link writes through a sentinel code land in the list head / tail,
    // writes through "not linked" are dropped
    function automatic void set_fwd(logic [COUNT_W-1:0] node, logic [COUNT_W-1:0] val);
        if (node < NUM_FRAMES) begin
            fwd_link[node] = val;
        end else if (node < NO_LINK) begin
            list_head[node - NUM_FRAMES] = val;
        end
    endfunction

    function automatic void set_back(logic [COUNT_W-1:0] node, logic [COUNT_W-1:0] val);
        if (node < NUM_FRAMES) begin
            back_link[node] = val;
        end else if (node < NO_LINK) begin
            list_tail[node - NUM_FRAMES] = val;
        end
    endfunction

    // apply one command to the list model and return the result it gives
    function automatic t_frame_result apply_list_command(logic [CMD_W-1:0] cmd,
                                                         logic [LIST_W-1:0] lst,
                                                         logic [FRAME_W-1:0] frm,
                                                         logic busy);
        t_frame_result      res;
        logic [COUNT_W-1:0] sentinel;
        logic [COUNT_W-1:0] first;
        logic [COUNT_W-1:0] after;
        logic [COUNT_W-1:0] nxt;
        logic [COUNT_W-1:0] prv;
        res      = '{ST_OK, '0, '0};
        sentinel = COUNT_W'(NUM_FRAMES + lst);
        case (cmd)
            CMD_INS_HEAD: begin
                if (busy) begin
                    res.status = ST_BUSY;
                end else begin
                    fwd_link[frm] = list_head[lst];
                    set_back(list_head[lst], COUNT_W'(frm));
                    list_head[lst] = COUNT_W'(frm);
                    back_link[frm] = sentinel;
                    if (list_len[lst] < COUNT_MAX) list_len[lst]++;
                end
            end
            CMD_INS_TAIL: begin
                back_link[frm] = list_tail[lst];
                fwd_link[frm]  = sentinel;
                set_fwd(list_tail[lst], COUNT_W'(frm));
                list_tail[lst] = COUNT_W'(frm);
                if (list_len[lst] < COUNT_MAX) list_len[lst]++;
            end
            CMD_POP_HEAD: begin
                first = list_head[lst];
                // own sentinel, other sentinel or no link all read as empty
                if (first >= NUM_FRAMES) begin
                    res.status = ST_EMPTY;
                end else begin
                    after          = fwd_link[first];
                    list_head[lst] = after;
                    set_back(after, sentinel);
                    fwd_link[first]  = NO_LINK;
                    back_link[first] = NO_LINK;
                    if (list_len[lst] > 0) list_len[lst]--;
                    res.popped = FRAME_W'(first);
                end
            end
            default: begin
                nxt = fwd_link[frm];
                prv = back_link[frm];
                if (list_head[lst] == sentinel) begin
                    res.status = ST_EMPTY;
                end else if (nxt == NO_LINK && prv == NO_LINK) begin
                    res.status = ST_UNLINKED;
                end else begin
                    // neighbors are relinked wherever they live
                    set_back(nxt, prv);
                    set_fwd(prv, nxt);
                    fwd_link[frm]  = NO_LINK;
                    back_link[frm] = NO_LINK;
                    if (list_len[lst] > 0) list_len[lst]--;
                end
            end
        endcase
        res.count = list_len[lst];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // sender: walks the directed table, then random items chosen from the
    // current list contents so that no already linked frame is inserted
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_directed_row      item;
        t_frame_result      res;
        int                 n;
        int                 gap;
        int                 target;
        int                 pick;
        int                 ins_pct;
        int                 idx;
        int                 f;
        int                 l;

        target = 20;
        for (f = 0; f < NUM_FRAMES; f++) begin
            fwd_link[f]   = NO_LINK;
            back_link[f]  = NO_LINK;
            on_list[f]    = 1'b0;
            owner_list[f] = '0;
        end
        for (l = 0; l < NUM_LISTS; l++) begin
            list_head[l] = COUNT_W'(NUM_FRAMES + l);
            list_tail[l] = COUNT_W'(NUM_FRAMES + l);
            list_len[l]  = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < ROW_COUNT + RANDOM_ITEMS; n++) begin
            // every fourth stretch of 120 items runs with no idling on either side
            no_idle = ((n / 120) % 4) == 3;

            if (n < ROW_COUNT) begin
                item = directed_rows[n];
            end else begin
                item = '0;
                // list occupancy target moves around: mostly short lists,
                // now and then a few hundred frames in flight
                if ((n % 200) == 0) begin
                    target = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 40);
                end
                ins_pct = (linked_pool.size() < target) ? 65 : 25;
                pick    = $urandom_range(0, 99);
                if (linked_pool.size() >= NUM_FRAMES - 1) pick = ins_pct;

                if (pick < ins_pct) begin
                    item.cmd  = $urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
                    item.lst  = LIST_W'($urandom_range(0, NUM_LISTS - 1));
                    item.busy = (item.cmd == CMD_INS_TAIL) ? 1'($urandom_range(0, 1))
                                                           : ($urandom_range(0, 9) == 0);
                    item.frm  = FRAME_W'($urandom);
                    // a refused head insert may name any frame, otherwise a free one
                    if (!(item.cmd == CMD_INS_HEAD && item.busy)) begin
                        while (on_list[item.frm]) item.frm = FRAME_W'($urandom);
                    end
                end else if (pick < ins_pct + (100 - ins_pct) / 2) begin
                    item.cmd  = CMD_POP_HEAD;
                    item.frm  = FRAME_W'($urandom);
                    item.busy = 1'($urandom_range(0, 1));
                    item.lst  = LIST_W'($urandom_range(0, NUM_LISTS - 1));
                    if (linked_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
                        item.lst = owner_list[linked_pool[$urandom_range(0,
                                               linked_pool.size() - 1)]];
                    end
                end else begin
                    item.cmd  = CMD_UNLINK;
                    item.busy = 1'($urandom_range(0, 1));
                    pick      = $urandom_range(0, 9);
                    if (linked_pool.size() != 0 && pick < 8) begin
                        idx      = $urandom_range(0, linked_pool.size() - 1);
                        item.frm = FRAME_W'(linked_pool[idx]);
                        // mostly the frame's own list, sometimes a wrong one
                        item.lst = (pick < 7) ? owner_list[item.frm]
                                              : LIST_W'($urandom_range(0, NUM_LISTS - 1));
                    end else begin
                        item.frm = FRAME_W'($urandom);
                        item.lst = LIST_W'($urandom_range(0, NUM_LISTS - 1));
                    end
                end
            end

            // sender idle before the item; valid stays up when there is no gap
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid     <= 1'b1;
            i_command      <= item.cmd;
            i_list_id      <= item.lst;
            i_frame_number <= item.frm;
            i_frame_busy   <= item.busy;
            @(posedge i_clk);
            // the clearing pass after reset shows up here as a long stall
            while (o_in_stall !== 1'b0) @(posedge i_clk);

            // item taken at this edge: update the model and the bookkeeping
            res = apply_list_command(item.cmd, item.lst, item.frm, item.busy);
            expected_results.push_back(item.typed ? item.want : res);
            cmd_seen[item.cmd]++;
            status_seen[res.status]++;
            if (res.status == ST_OK) begin
                if (item.cmd == CMD_INS_HEAD || item.cmd == CMD_INS_TAIL) begin
                    on_list[item.frm]    = 1'b1;
                    owner_list[item.frm] = item.lst;
                    linked_pool.push_back(int'(item.frm));
                end else begin
                    f          = (item.cmd == CMD_POP_HEAD) ? int'(res.popped)
                                                            : int'(item.frm);
                    on_list[f] = 1'b0;
                    for (idx = 0; idx < linked_pool.size(); idx++) begin
                        if (linked_pool[idx] == f) begin
                            linked_pool.delete(idx);
                            break;
                        end
                    end
                end
            end
        end
        i_in_valid <= 1'b0;

        // drain: every expected result back, then a wait for strays
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d items: %0d head inserts, %0d tail inserts, %0d pops, %0d unlinks",
                 ROW_COUNT + RANDOM_ITEMS, cmd_seen[CMD_INS_HEAD], cmd_seen[CMD_INS_TAIL],
                 cmd_seen[CMD_POP_HEAD], cmd_seen[CMD_UNLINK]);
        $display("results: %0d ok, %0d empty, %0d busy, %0d not linked; %0d errors",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BUSY],
                 status_seen[ST_UNLINKED], err_count);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stall before each result item, compared field by field
    // with the oldest expectation
    // ------------------------------------------------------------------------
    initial begin : result_check
        t_frame_result want;
        int            hold;
        hold = $urandom_range(0, 13);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                result_seen++;
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN) begin
                        $display("result item %0d with nothing expected:", result_seen);
                        $display("  status %0d frame %0d count %0d",
                                 o_status, o_popped_frame, o_list_count);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_popped_frame !== want.popped ||
                        o_list_count !== want.count) begin
                        err_count++;
                        if (err_count <= MAX_SHOWN) begin
                            $display("result item %0d mismatch:", result_seen);
                            $display("  expected status %0d frame %0d count %0d",
                                     want.status, want.popped, want.count);
                            $display("  got      status %0d frame %0d count %0d",
                                     o_status, o_popped_frame, o_list_count);
                        end
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, 13);
            end
            // one nonblocking write of the stall per edge
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // run limit: several times the slowest legal run including the clearing pass
    initial begin : run_limit
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/pflm_pkg.sv
rtl/pflm_ram.sv
rtl/pflm_ctrl.sv
rtl/pflm_dp.sv
rtl/page_frame_list_manager_top.sv
rtl/pflm_checker.sv
dv/page_frame_list_manager_top_tb.sv
